// ===== rtl/slpp_pkg.sv =====
package slpp_pkg;

    // field widths of one item
    localparam int COORD_W  = 31;
    localparam int RAD_W    = 30;
    localparam int COLOUR_W = 8;
    localparam int ACTION_W = 2;

    // item action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD_CIRCLE = 2'd0,
        ACT_ADD_RECT   = 2'd1,
        ACT_QUERY      = 2'd2,
        ACT_NONE       = 2'd3
    } t_action;

    // control sequencer
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // one stored shape; for a circle x_high_or_radius holds the radius
    typedef struct packed {
        logic                is_circle;
        logic [COORD_W-1:0]  x_low;
        logic [COORD_W-1:0]  y_low;
        logic [COORD_W-1:0]  x_high_or_radius;
        logic [COORD_W-1:0]  y_high;
        logic [COLOUR_W-1:0] colour;
    } t_shape;

endpackage

// ===== rtl/slpp_ram.sv =====
module slpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/shape_list_pixel_painter.sv =====
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+----------------------------------------------
// command  | in        | i_start while !o_busy | i_action, i_x_first, i_y_first, i_x_second,
//          |           |                       | i_y_second, i_radius, i_paint
// result   | out       | o_valid, one cycle    | o_covered, o_pixel_colour, o_list_full
//
// Adds and queries on an empty list answer the cycle after they are taken; action code 3
// gives no result. A query reads the shape memory newest first, one shape per cycle, into a
// three-stage compare pipeline; the scan stops at the first shape that covers the pixel,
// or once every stored shape has gone through the compare.
// o_busy is high only during that scan; results cannot be stalled. Synchronous active-low
// reset empties the list; the memory itself is never cleared.
module shape_list_pixel_painter #(
    parameter int MAX_SHAPES = 2048
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic [slpp_pkg::ACTION_W-1:0]         i_action,
    input  logic signed [slpp_pkg::COORD_W-1:0]   i_x_first,
    input  logic signed [slpp_pkg::COORD_W-1:0]   i_y_first,
    input  logic signed [slpp_pkg::COORD_W-1:0]   i_x_second,
    input  logic signed [slpp_pkg::COORD_W-1:0]   i_y_second,
    input  logic [slpp_pkg::RAD_W-1:0]            i_radius,
    input  logic [slpp_pkg::COLOUR_W-1:0]         i_paint,
    output logic                                  o_valid,
    output logic                                  o_covered,
    output logic [slpp_pkg::COLOUR_W-1:0]         o_pixel_colour,
    output logic                                  o_list_full
);

    localparam int AW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
    localparam int CW = $clog2(MAX_SHAPES + 1);
    localparam int SW = $bits(slpp_pkg::t_shape);
    localparam int CO = slpp_pkg::COORD_W;
    localparam logic [CW-1:0] CntMax = CW'(MAX_SHAPES);

    // control state
    slpp_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_left, n_left;
    logic             r_v1, r_v2, r_v3;

    // query pixel
    logic [CO-1:0]    r_qx, n_qx;
    logic [CO-1:0]    r_qy, n_qy;

    // result register
    logic                          r_out_valid, n_out_valid;
    logic                          r_covered, n_covered;
    logic [slpp_pkg::COLOUR_W-1:0] r_colour, n_colour;
    logic                          r_full, n_full;

    // memory ports
    logic              mem_we;
    logic [AW-1:0]     mem_raddr;
    slpp_pkg::t_shape  mem_wdata;
    slpp_pkg::t_shape  mem_rdata;
    logic [SW-1:0]     mem_rdata_raw;

    // compare pipeline
    logic                          r_s2_circle, r_s2_rect_hit;
    logic [CO-1:0]                 r_s2_dx, r_s2_dy, r_s2_r;
    logic [slpp_pkg::COLOUR_W-1:0] r_s2_colour;
    logic                          r_s3_circle, r_s3_rect_hit;
    logic [2*CO-1:0]               r_s3_dx2, r_s3_dy2, r_s3_r2;
    logic [slpp_pkg::COLOUR_W-1:0] r_s3_colour;

    logic               accept;
    logic               full;
    logic               issue;
    logic               s3_hit;
    logic               scan_done;
    logic [CW-1:0]      left_m1;
    slpp_pkg::t_action  act;

    logic signed [CO:0] dx_d, dy_d;
    logic [CO:0]        dx_n, dy_n;
    logic               rect_hit;
    logic [2*CO:0]      dist2;

    assign act     = slpp_pkg::t_action'(i_action);
    assign o_busy  = (r_state != slpp_pkg::ST_IDLE);
    assign accept  = i_start && !o_busy;
    assign full    = (r_count >= CntMax);
    assign left_m1 = r_left - CW'(1);

    // shape store
    assign mem_raddr = left_m1[AW-1:0];
    always_comb begin
        mem_wdata.is_circle        = (act == slpp_pkg::ACT_ADD_CIRCLE);
        mem_wdata.x_low            = i_x_first;
        mem_wdata.y_low            = i_y_first;
        mem_wdata.x_high_or_radius = (act == slpp_pkg::ACT_ADD_CIRCLE) ?
                                     {1'b0, i_radius} : i_x_second;
        mem_wdata.y_high           = (act == slpp_pkg::ACT_ADD_CIRCLE) ?
                                     '0 : i_y_second;
        mem_wdata.colour           = i_paint;
    end

    slpp_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_SHAPES)
    ) u_shape_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata_raw)
    );
    assign mem_rdata = slpp_pkg::t_shape'(mem_rdata_raw);

    // stage 1: distances and rectangle test on the shape just read
    always_comb begin
        dx_d = $signed({r_qx[CO-1], r_qx})
             - $signed({mem_rdata.x_low[CO-1], mem_rdata.x_low});
        dy_d = $signed({r_qy[CO-1], r_qy})
             - $signed({mem_rdata.y_low[CO-1], mem_rdata.y_low});
        dx_n = dx_d[CO] ? ((CO+1)'(0) - dx_d) : dx_d;
        dy_n = dy_d[CO] ? ((CO+1)'(0) - dy_d) : dy_d;
        rect_hit = ($signed(r_qx) >= $signed(mem_rdata.x_low))
                && ($signed(r_qx) <= $signed(mem_rdata.x_high_or_radius))
                && ($signed(r_qy) >= $signed(mem_rdata.y_low))
                && ($signed(r_qy) <= $signed(mem_rdata.y_high));
    end

    // stages 2 and 3 datapath, no reset
    always_ff @(posedge i_clk) begin
        r_s2_circle   <= mem_rdata.is_circle;
        r_s2_rect_hit <= rect_hit;
        r_s2_dx       <= dx_n[CO-1:0];
        r_s2_dy       <= dy_n[CO-1:0];
        r_s2_r        <= mem_rdata.x_high_or_radius;
        r_s2_colour   <= mem_rdata.colour;

        r_s3_circle   <= r_s2_circle;
        r_s3_rect_hit <= r_s2_rect_hit;
        r_s3_dx2      <= r_s2_dx * r_s2_dx;
        r_s3_dy2      <= r_s2_dy * r_s2_dy;
        r_s3_r2       <= r_s2_r * r_s2_r;
        r_s3_colour   <= r_s2_colour;
    end

    // final compare; the first hit out of the pipe is the newest covering shape
    assign dist2     = {1'b0, r_s3_dx2} + {1'b0, r_s3_dy2};
    assign s3_hit    = r_v3 && (r_s3_circle ? (dist2 <= {1'b0, r_s3_r2}) : r_s3_rect_hit);
    assign scan_done = s3_hit || ((r_left == '0) && !r_v1 && !r_v2 && !r_v3);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            slpp_pkg::ST_IDLE: begin
                if (accept && (act == slpp_pkg::ACT_QUERY) && (r_count != '0)) begin
                    n_state = slpp_pkg::ST_SCAN;
                end
            end
            slpp_pkg::ST_SCAN: begin
                if (scan_done) begin
                    n_state = slpp_pkg::ST_IDLE;
                end
            end
            default: n_state = slpp_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        n_out_valid = 1'b0;
        n_covered   = 1'b0;
        n_colour    = '0;
        n_full      = 1'b0;
        n_count     = r_count;
        n_left      = r_left;
        n_qx        = r_qx;
        n_qy        = r_qy;
        mem_we      = 1'b0;
        issue       = 1'b0;
        case (r_state)
            slpp_pkg::ST_IDLE: begin
                if (accept) begin
                    case (act)
                        slpp_pkg::ACT_ADD_CIRCLE, slpp_pkg::ACT_ADD_RECT: begin
                            n_out_valid = 1'b1;
                            if (full) begin
                                n_full = 1'b1;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        slpp_pkg::ACT_QUERY: begin
                            n_qx = i_x_first;
                            n_qy = i_y_first;
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                            end else begin
                                n_left = r_count;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            slpp_pkg::ST_SCAN: begin
                issue = (r_left != '0) && !s3_hit;
                if (issue) begin
                    n_left = left_m1;
                end
                if (scan_done) begin
                    n_out_valid = 1'b1;
                    n_covered   = s3_hit;
                    n_colour    = s3_hit ? r_s3_colour : '0;
                    n_left      = '0;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slpp_pkg::ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_v1        <= issue;
            r_v2        <= r_v1 && !s3_hit;
            r_v3        <= r_v2 && !s3_hit;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_qx      <= n_qx;
        r_qy      <= n_qy;
        r_covered <= n_covered;
        r_colour  <= n_colour;
        r_full    <= n_full;
    end

    assign o_valid        = r_out_valid;
    assign o_covered      = r_covered;
    assign o_pixel_colour = r_colour;
    assign o_list_full    = r_full;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntMax)
        else $error("shape count above capacity");

    a_add_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ((act == slpp_pkg::ACT_ADD_CIRCLE) || (act == slpp_pkg::ACT_ADD_RECT)))
        |=> o_valid)
        else $error("add item without result");

    a_pipe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2 || r_v3) |-> (r_state == slpp_pkg::ST_SCAN))
        else $error("compare pipeline active outside scan");

    a_full_not_covered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_list_full) |-> (!o_covered && (o_pixel_colour == '0)))
        else $error("dropped add reports coverage");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == slpp_pkg::ST_SCAN) && scan_done) |=> (o_valid && !o_busy))
        else $error("scan finished without result");

endmodule
